// File: src/arevca_pkg.sv
// shared types, constants and codes for the attack/release envelope gain unit
// no dependencies
package arevca_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int LEVEL_W     = 17;   // 1.16 unsigned gain or level
   localparam int LEN_W       = 16;
   localparam int STEP_W      = 18;   // signed peak step
   localparam int WIDE_W      = 19;   // signed working width for level sums
   localparam int PROD_W      = LEVEL_W + 1 + SAMPLE_W;
   localparam int GAIN_SHIFT  = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int DEF_BIAS_SLEW_STEP = 64;

   localparam int DIVIDEND_W = LEVEL_W;
   localparam int DIVISOR_W  = LEN_W;
   localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

   localparam logic [LEVEL_W-1:0] UNITY = LEVEL_W'(65536);

   localparam logic [LEVEL_W-1:0] RST_PEAK_TARGET = LEVEL_W'(65536);
   localparam logic [LEN_W-1:0]   RST_ATTACK_LEN  = LEN_W'(1);
   localparam logic [LEN_W-1:0]   RST_RELEASE_LEN = LEN_W'(1);
   localparam logic [LEVEL_W-1:0] RST_BIAS_TARGET = '0;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_PEAK_TARGET = 2'd0,
      CSR_ATTACK_LEN  = 2'd1,
      CSR_RELEASE_LEN = 2'd2,
      CSR_BIAS_TARGET = 2'd3
   } csr_index_type;

   // input commands
   typedef enum logic [1:0] {
      CMD_SAMPLE  = 2'd0,
      CMD_ATTACK  = 2'd1,
      CMD_RELEASE = 2'd2,
      CMD_UNUSED  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      PH_OFF     = 2'd0,
      PH_ATTACK  = 2'd1,
      PH_HOLD    = 2'd2,
      PH_RELEASE = 2'd3
   } phase_type;

   // work items passed from front to back
   typedef enum logic [1:0] {
      OP_SAMPLE,
      OP_ATTACK,
      OP_RELEASE
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SLEW,
      ST_GAIN,
      ST_MUL,
      ST_OUT
   } back_state_type;

   typedef struct packed {
      logic [1:0]                 cmd;
      logic signed [SAMPLE_W-1:0] sample_in;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic [1:0]                 env_phase;
   } rsp_type;

   typedef struct packed {
      op_type                     op;
      logic signed [SAMPLE_W-1:0] sample;
   } op_item_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] peak_target;
      logic [LEN_W-1:0]   attack_len;
      logic [LEN_W-1:0]   release_len;
      logic [LEVEL_W-1:0] bias_target;
   } cfg_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_rsp_type;

endpackage

// File: src/arevca_fifo.sv
// small first-in first-out queue of any packed item type
// depends on arevca_pkg for the default depth
module arevca_fifo #(
   parameter int  DEPTH = arevca_pkg::QUEUE_DEPTH,
   parameter type item_type = logic
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_en,
   input  item_type wr_data,
   output logic     full,
   input  logic     rd_en,
   output item_type rd_data,
   output logic     empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type         store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         store_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// File: src/arevca_front.sv
// front end: accepts commands, drops unused codes, queues work for the back end
// depends on arevca_pkg and arevca_fifo
module arevca_front #(
   parameter int QUEUE_DEPTH = arevca_pkg::QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  arevca_pkg::req_type      req_data,
   output logic                     full,
   output logic                     op_valid,
   output arevca_pkg::op_item_type  op_item,
   input  logic                     op_take
);
   import arevca_pkg::*;

   op_item_type item;
   logic        keep;
   logic        op_empty;

   always_comb begin
      item.sample = req_data.sample_in;
      item.op     = OP_SAMPLE;
      keep        = 1'b1;
      unique case (cmd_type'(req_data.cmd))
         CMD_SAMPLE:  item.op = OP_SAMPLE;
         CMD_ATTACK:  item.op = OP_ATTACK;
         CMD_RELEASE: item.op = OP_RELEASE;
         default:     keep    = 1'b0;
      endcase
   end

   arevca_fifo #(
      .DEPTH     (QUEUE_DEPTH),
      .item_type (op_item_type)
   ) u_op_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push && keep),
      .wr_data (item),
      .full    (full),
      .rd_en   (op_take),
      .rd_data (op_item),
      .empty   (op_empty)
   );

   assign op_valid = !op_empty;

endmodule

// File: src/arevca_div.sv
// restoring divider, one quotient bit per cycle, for the trigger step
// depends on arevca_pkg
module arevca_div (
   input  logic                    clock,
   input  logic                    reset,
   input  arevca_pkg::div_req_type div_req,
   output arevca_pkg::div_rsp_type div_rsp
);
   import arevca_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic [DIVISOR_W:0]    rem_shift;
   logic [DIVISOR_W:0]    rem_diff;
   logic                  fits;

   assign rem_shift = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign rem_diff  = rem_shift - {1'b0, divisor_ff};
   assign fits      = (rem_shift >= {1'b0, divisor_ff});

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         cnt_in     = '0;
         rem_in     = '0;
         quo_in     = div_req.dividend;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so it fits the divisor width
         rem_in = fits ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// File: src/arevca_back.sv
// back end: envelope state, trigger step set-up, bias slew, gain and multiply
// depends on arevca_pkg; drives arevca_div through its request struct
module arevca_back #(
   parameter int BIAS_SLEW_STEP = arevca_pkg::DEF_BIAS_SLEW_STEP
) (
   input  logic                    clock,
   input  logic                    reset,
   input  arevca_pkg::cfg_type     cfg,
   input  logic                    op_valid,
   input  arevca_pkg::op_item_type op_item,
   output logic                    op_take,
   output arevca_pkg::div_req_type div_req,
   input  arevca_pkg::div_rsp_type div_rsp,
   output logic                    rsp_push,
   output arevca_pkg::rsp_type     rsp_item,
   input  logic                    rsp_full
);
   import arevca_pkg::*;

   localparam logic signed [WIDE_W-1:0] SLEW = WIDE_W'(BIAS_SLEW_STEP);

   back_state_type state_ff, state_in;
   phase_type      phase_ff, phase_in;
   logic [LEVEL_W-1:0]        peak_ff, peak_in;
   logic [LEVEL_W-1:0]        bias_ff, bias_in;
   logic signed [STEP_W-1:0]  step_ff, step_in;
   logic                      neg_ff, neg_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [LEVEL_W-1:0]        gain_ff, gain_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;

   logic is_trigger;
   logic signed [WIDE_W-1:0] peak_w, bias_w, ptgt_w, btgt_w;
   logic signed [WIDE_W-1:0] delta, bias_up, bias_dn, step_w, psum;
   logic signed [WIDE_W-1:0] pa1, pa2, pa3, pr;
   logic [WIDE_W-1:0]        gsum;
   logic [LEN_W-1:0]         att_len, rel_len;
   logic                     step_pos, step_neg;
   phase_type                phase_next;
   logic [LEVEL_W-1:0]       peak_next;

   assign is_trigger = (op_item.op == OP_ATTACK) || (op_item.op == OP_RELEASE);

   assign peak_w = signed'(WIDE_W'(peak_ff));
   assign bias_w = signed'(WIDE_W'(bias_ff));
   assign ptgt_w = signed'(WIDE_W'(cfg.peak_target));
   assign btgt_w = signed'(WIDE_W'(cfg.bias_target));
   assign delta  = ptgt_w - peak_w;
   assign att_len = (cfg.attack_len == '0) ? LEN_W'(1) : cfg.attack_len;
   assign rel_len = (cfg.release_len == '0) ? LEN_W'(1) : cfg.release_len;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (op_valid) begin
               state_in = is_trigger ? ST_DIV : ST_SLEW;
            end
         end
         ST_DIV:  if (div_rsp.done) state_in = ST_IDLE;
         ST_SLEW: state_in = ST_GAIN;
         ST_GAIN: state_in = ST_MUL;
         ST_MUL:  state_in = ST_OUT;
         ST_OUT:  if (!rsp_full) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // handshakes and divider request
   always_comb begin
      op_take          = 1'b0;
      rsp_push         = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = att_len;
      unique case (state_ff)
         ST_IDLE: begin
            op_take = op_valid;
            if (op_valid && is_trigger) begin
               div_req.start = 1'b1;
               if (op_item.op == OP_ATTACK) begin
                  // magnitude of the distance to the target
                  div_req.dividend = delta[WIDE_W-1] ? DIVIDEND_W'(-delta)
                                                     : DIVIDEND_W'(delta);
               end else begin
                  div_req.dividend = peak_ff;
                  div_req.divisor  = rel_len;
               end
            end
         end
         ST_OUT:  rsp_push = !rsp_full;
         default: ;
      endcase
   end

   // peak update after a sample
   assign step_w   = WIDE_W'(step_ff);
   assign psum     = peak_w + step_w;
   assign step_pos = !step_ff[STEP_W-1] && (step_ff != '0);
   assign step_neg = step_ff[STEP_W-1];

   always_comb begin
      pa1 = psum;
      if ((step_pos && psum > ptgt_w) || (step_neg && psum < ptgt_w)) begin
         pa1 = ptgt_w;
      end
      pa2 = (pa1 > signed'(WIDE_W'(UNITY))) ? signed'(WIDE_W'(UNITY)) : pa1;
      pa3 = pa2[WIDE_W-1] ? '0 : pa2;
      pr  = psum[WIDE_W-1] ? '0 : psum;

      phase_next = phase_ff;
      peak_next  = peak_ff;
      case (phase_ff)
         PH_ATTACK: begin
            peak_next = pa3[LEVEL_W-1:0];
            if ((step_pos && pa3 >= ptgt_w) || (step_neg && pa3 <= ptgt_w)) begin
               phase_next = PH_HOLD;
            end
         end
         PH_RELEASE: begin
            peak_next = pr[LEVEL_W-1:0];
            if (pr == '0) begin
               phase_next = PH_OFF;
            end
         end
         default: ;
      endcase
   end

   assign bias_up = bias_w + SLEW;
   assign bias_dn = bias_w - SLEW;
   assign gsum    = (phase_ff == PH_OFF) ? unsigned'(bias_w) : unsigned'(bias_w + peak_w);

   always_comb begin
      phase_in  = phase_ff;
      peak_in   = peak_ff;
      bias_in   = bias_ff;
      step_in   = step_ff;
      neg_in    = neg_ff;
      sample_in = sample_ff;
      gain_in   = gain_ff;
      prod_in   = prod_ff;
      case (state_ff)
         ST_IDLE: begin
            if (op_valid) begin
               sample_in = op_item.sample;
               if (op_item.op == OP_ATTACK) begin
                  phase_in = PH_ATTACK;
                  neg_in   = delta[WIDE_W-1];
               end else if (op_item.op == OP_RELEASE) begin
                  phase_in = PH_RELEASE;
                  neg_in   = 1'b1;
               end
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               step_in = neg_ff ? -signed'(STEP_W'(div_rsp.quotient))
                                :  signed'(STEP_W'(div_rsp.quotient));
            end
         end
         ST_SLEW: begin
            if (bias_w < btgt_w) begin
               bias_in = (bias_up > btgt_w) ? cfg.bias_target : bias_up[LEVEL_W-1:0];
            end else if (bias_w > btgt_w) begin
               bias_in = (bias_dn < btgt_w) ? cfg.bias_target : bias_dn[LEVEL_W-1:0];
            end
         end
         ST_GAIN: begin
            gain_in = (gsum > WIDE_W'(UNITY)) ? UNITY : gsum[LEVEL_W-1:0];
         end
         ST_MUL: begin
            prod_in = signed'({1'b0, gain_ff}) * sample_ff;
         end
         ST_OUT: begin
            if (!rsp_full) begin
               phase_in = phase_next;
               peak_in  = peak_next;
            end
         end
         default: ;
      endcase
   end

   assign rsp_item.sample_out = prod_ff[GAIN_SHIFT +: SAMPLE_W];
   assign rsp_item.env_phase  = phase_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_OFF;
         peak_ff  <= '0;
         bias_ff  <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         peak_ff  <= peak_in;
         bias_ff  <= bias_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff    <= neg_in;
      sample_ff <= sample_in;
      gain_ff   <= gain_in;
      prod_ff   <= prod_in;
   end

endmodule

// File: src/attack_release_envelope_vca_unit.sv
// top level of the attack/release envelope gain unit: registers, front, back
// depends on arevca_pkg, arevca_front, arevca_div, arevca_back, arevca_fifo
//
//   channel   handshake        payload                 moves
//   input     push / full      req_data (cmd, sample)  one command per transfer
//   result    pop / empty      rsp_data (sample, ph)   one result per sample
//   config    valid / ready    csr_index, csr_data     one register write
//
// a sample passes the back end through its take, slew, gain, multiply and output steps;
// a trigger is taken and then waits on the divider, which gives one quotient bit per cycle.
// reset is synchronous; it clears the envelope state and the queues and loads the register defaults.
// a full result queue holds the back end in its output step; commands keep
// queueing in front until the front queue is full.
module attack_release_envelope_vca_unit #(
   parameter int BIAS_SLEW_STEP = arevca_pkg::DEF_BIAS_SLEW_STEP,
   parameter int QUEUE_DEPTH    = arevca_pkg::QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  arevca_pkg::req_type           req_data,
   output logic                          full,
   input  logic                          pop,
   output arevca_pkg::rsp_type           rsp_data,
   output logic                          empty,
   input  logic                          valid,
   output logic                          ready,
   input  logic [1:0]                    csr_index,
   input  logic [arevca_pkg::LEVEL_W-1:0] csr_data
);
   import arevca_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   op_item_type op_item;
   logic        op_valid, op_take;
   div_req_type div_req;
   div_rsp_type div_rsp;
   rsp_type     rsp_item;
   logic        rsp_push, rsp_full;

   assign ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (valid && ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_PEAK_TARGET: cfg_in.peak_target = csr_data;
            CSR_ATTACK_LEN:  cfg_in.attack_len  = csr_data[LEN_W-1:0];
            CSR_RELEASE_LEN: cfg_in.release_len = csr_data[LEN_W-1:0];
            CSR_BIAS_TARGET: cfg_in.bias_target = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.peak_target <= RST_PEAK_TARGET;
         cfg_ff.attack_len  <= RST_ATTACK_LEN;
         cfg_ff.release_len <= RST_RELEASE_LEN;
         cfg_ff.bias_target <= RST_BIAS_TARGET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   arevca_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_data (req_data),
      .full     (full),
      .op_valid (op_valid),
      .op_item  (op_item),
      .op_take  (op_take)
   );

   arevca_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   arevca_back #(
      .BIAS_SLEW_STEP (BIAS_SLEW_STEP)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .op_valid (op_valid),
      .op_item  (op_item),
      .op_take  (op_take),
      .div_req  (div_req),
      .div_rsp  (div_rsp),
      .rsp_push (rsp_push),
      .rsp_item (rsp_item),
      .rsp_full (rsp_full)
   );

   // result queue parts the back end from the consumer
   arevca_fifo #(
      .DEPTH     (QUEUE_DEPTH),
      .item_type (rsp_type)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rsp_push),
      .wr_data (rsp_item),
      .full    (rsp_full),
      .rd_en   (pop),
      .rd_data (rsp_data),
      .empty   (empty)
   );

endmodule

// File: tb/arevca_checker.sv
// envelope checker: watches the command, result and register channels of the gain unit,
// predicts each result from its own copy of the envelope state and compares field by field
// depends on arevca_pkg
`timescale 1ns / 100ps

module arevca_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  arevca_pkg::req_type           req_data,
   input  logic                          full,
   input  logic                          pop,
   input  arevca_pkg::rsp_type           rsp_data,
   input  logic                          empty,
   input  logic                          valid,
   input  logic                          ready,
   input  logic [1:0]                    csr_index,
   input  logic [arevca_pkg::LEVEL_W-1:0] csr_data,
   output int                            fail_count,
   output int                            waiting,
   output int                            checked
);
   import arevca_pkg::*;

   localparam int SLEW_STEP = DEF_BIAS_SLEW_STEP;

   cfg_type                  cfg;
   phase_type                phase_now;
   logic [LEVEL_W-1:0]       peak_lvl;
   logic [LEVEL_W-1:0]       bias_lvl;
   logic signed [STEP_W-1:0] peak_step;
   rsp_type                  expected_q[$];

   always @(posedge clock) begin : watch
      int      len;
      int      tgt;
      int      pk;
      int      stp;
      int      bias;
      int      btgt;
      int      gain;
      longint  prod;
      rsp_type res;
      rsp_type want;

      if (reset) begin
         cfg.peak_target = RST_PEAK_TARGET;
         cfg.attack_len  = RST_ATTACK_LEN;
         cfg.release_len = RST_RELEASE_LEN;
         cfg.bias_target = RST_BIAS_TARGET;
         phase_now       = PH_OFF;
         peak_lvl        = '0;
         bias_lvl        = '0;
         peak_step       = '0;
         expected_q.delete();
         fail_count      = 0;
         checked         = 0;
      end else begin
         // result transfer: compare against the oldest prediction
         if (pop && !empty) begin
            if (expected_q.size() == 0) begin
               $error("unexpected result: sample_out %0d env_phase %0d",
                      rsp_data.sample_out, rsp_data.env_phase);
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               checked++;
               if (rsp_data.sample_out !== want.sample_out) begin
                  $error("sample_out mismatch: expected %0d, actual %0d",
                         want.sample_out, rsp_data.sample_out);
                  fail_count++;
               end
               if (rsp_data.env_phase !== want.env_phase) begin
                  $error("env_phase mismatch: expected %0d, actual %0d",
                         want.env_phase, rsp_data.env_phase);
                  fail_count++;
               end
            end
         end

         // command transfer: advance the envelope copy
         if (push && !full) begin
            tgt = int'(cfg.peak_target);
            pk  = int'(peak_lvl);
            case (cmd_type'(req_data.cmd))
               CMD_ATTACK: begin
                  len       = (cfg.attack_len == '0) ? 1 : int'(cfg.attack_len);
                  peak_step = STEP_W'((tgt - pk) / len);
                  phase_now = PH_ATTACK;
               end
               CMD_RELEASE: begin
                  len       = (cfg.release_len == '0) ? 1 : int'(cfg.release_len);
                  peak_step = STEP_W'(-(pk / len));
                  phase_now = PH_RELEASE;
               end
               CMD_SAMPLE: begin
                  bias = int'(bias_lvl);
                  btgt = int'(cfg.bias_target);
                  if (bias < btgt)
                     bias = (bias + SLEW_STEP > btgt) ? btgt : bias + SLEW_STEP;
                  else if (bias > btgt)
                     bias = (bias - SLEW_STEP < btgt) ? btgt : bias - SLEW_STEP;
                  bias_lvl = LEVEL_W'(bias);

                  // gain uses the peak before this sample's step
                  gain = (phase_now == PH_OFF) ? bias : bias + pk;
                  if (gain > int'(UNITY))
                     gain = int'(UNITY);
                  prod = longint'(gain) * longint'(req_data.sample_in);
                  res.sample_out = SAMPLE_W'(prod >>> GAIN_SHIFT);

                  stp = int'(peak_step);
                  if (phase_now == PH_ATTACK) begin
                     pk = pk + stp;
                     if (stp > 0 && pk > tgt)
                        pk = tgt;
                     if (stp < 0 && pk < tgt)
                        pk = tgt;
                     if (pk > int'(UNITY))
                        pk = int'(UNITY);
                     if (pk < 0)
                        pk = 0;
                     // a target above unity is never reached, so attack never ends
                     if ((stp > 0 && pk >= tgt) || (stp < 0 && pk <= tgt))
                        phase_now = PH_HOLD;
                  end else if (phase_now == PH_RELEASE) begin
                     pk = pk + stp;
                     if (pk <= 0) begin
                        pk        = 0;
                        phase_now = PH_OFF;
                     end
                  end
                  peak_lvl      = LEVEL_W'(pk);
                  res.env_phase = phase_now;
                  expected_q.push_back(res);
               end
               default: ;   // unused code gives nothing
            endcase
         end

         if (valid && ready) begin
            case (csr_index_type'(csr_index))
               CSR_PEAK_TARGET: cfg.peak_target = csr_data;
               CSR_ATTACK_LEN:  cfg.attack_len  = csr_data[LEN_W-1:0];
               CSR_RELEASE_LEN: cfg.release_len = csr_data[LEN_W-1:0];
               CSR_BIAS_TARGET: cfg.bias_target = csr_data;
               default: ;
            endcase
         end
      end
      waiting = expected_q.size();
   end

endmodule

// File: tb/tb_attack_release_envelope_vca_unit.sv
// top of the gain unit testbench: clock, reset, command and register stimulus, verdict
// depends on arevca_pkg, attack_release_envelope_vca_unit and arevca_checker
`timescale 1ns / 100ps

module tb_attack_release_envelope_vca_unit;
   import arevca_pkg::*;

   localparam int SETTLE_CYCLES = 80;       // covers a few queued divisions
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 105;

   logic               clock = 1'b0;
   logic               reset;
   logic               push;
   req_type            req_data;
   logic               full;
   logic               pop = 1'b0;
   rsp_type            rsp_data;
   logic               empty;
   logic               valid;
   logic               ready;
   logic [1:0]         csr_index;
   logic [LEVEL_W-1:0] csr_data;

   int   fail_count;
   int   waiting;
   int   checked;
   int   cycle_count = 0;
   int   pop_hold = 0;
   logic rsp_taken = 1'b0;
   logic calm = 1'b0;

   int   n_samples = 0;
   int   n_triggers = 0;
   int   n_unused = 0;
   int   n_settings = 0;

   attack_release_envelope_vca_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_data  (req_data),
      .full      (full),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .empty     (empty),
      .valid     (valid),
      .ready     (ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   arevca_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .req_data   (req_data),
      .full       (full),
      .pop        (pop),
      .rsp_data   (rsp_data),
      .empty      (empty),
      .valid      (valid),
      .ready      (ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .waiting    (waiting),
      .checked    (checked)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // mostly no gap, some short ones, a few long
   function automatic int pick_gap();
      int r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(10, 45);
   endfunction

   function automatic logic [SAMPLE_W-1:0] rand_sample();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return '0;
         3:       return '1;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic logic [LEVEL_W-1:0] pick_level(input int usual_max);
      int r;
      r = $urandom_range(0, 5);
      case (r)
         0:       return '0;
         1:       return UNITY;
         2:       return '1;
         3:       return LEVEL_W'($urandom_range(0, 131071));
         default: return LEVEL_W'($urandom_range(0, usual_max));
      endcase
   endfunction

   // short lengths dominate so attacks reach hold inside a sequence
   function automatic logic [LEN_W-1:0] pick_len();
      int r;
      r = $urandom_range(0, 7);
      case (r)
         0:       return '0;
         1:       return '1;
         2:       return LEN_W'($urandom);
         default: return LEN_W'($urandom_range(1, 12));
      endcase
   endfunction

   // result side: pop stalls for a random time after each transfer
   always @(posedge clock)
      rsp_taken <= pop && !empty;

   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (rsp_taken)
            pop_hold = pick_gap();
         if (pop_hold > 0) begin
            pop <= 1'b0;
            pop_hold--;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   task automatic send_cmd(input cmd_type code, input logic [SAMPLE_W-1:0] value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      push     <= 1'b1;
      req_data <= '{code, value};
      @(posedge clock);
      while (full)
         @(posedge clock);
      @(negedge clock);
      case (code) inside
         CMD_SAMPLE:               n_samples++;
         CMD_ATTACK, CMD_RELEASE:  n_triggers++;
         default:                  n_unused++;
      endcase
   endtask

   // sender holds off until every expected result has arrived, then lets triggers finish
   task automatic settle();
      push <= 1'b0;
      while (waiting != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [LEVEL_W-1:0] value);
      valid     <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic setup(input logic [LEVEL_W-1:0] peak_tgt, input logic [LEN_W-1:0] att,
                        input logic [LEN_W-1:0] rel, input logic [LEVEL_W-1:0] bias_tgt);
      settle();
      write_reg(CSR_PEAK_TARGET, peak_tgt);
      write_reg(CSR_ATTACK_LEN, LEVEL_W'(att));
      write_reg(CSR_RELEASE_LEN, LEVEL_W'(rel));
      write_reg(CSR_BIAS_TARGET, bias_tgt);
      valid <= 1'b0;
      n_settings++;
   endtask

   // mostly attack / samples / release sequences, the rest loose commands
   task automatic run_random(input int quota);
      int      done_items;
      int      k;
      int      m;
      cmd_type code;
      done_items = 0;
      while (done_items < quota) begin
         if ($urandom_range(0, 99) < 75) begin
            k = $urandom_range(1, 14);
            m = $urandom_range(1, 14);
            send_cmd(CMD_ATTACK, SAMPLE_W'($urandom));
            repeat (k) send_cmd(CMD_SAMPLE, rand_sample());
            send_cmd(CMD_RELEASE, SAMPLE_W'($urandom));
            repeat (m) send_cmd(CMD_SAMPLE, rand_sample());
            done_items += k + m + 2;
         end else begin
            code = cmd_type'($urandom_range(0, 3));
            send_cmd(code, rand_sample());
            if (code != CMD_UNUSED)
               done_items++;
         end
      end
   endtask

   initial begin
      reset     = 1'b1;
      push      = 1'b0;
      req_data  = '0;
      valid     = 1'b0;
      csr_index = CSR_PEAK_TARGET;
      csr_data  = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: unity target, one-sample ramps, no bias
      send_cmd(CMD_SAMPLE, 16'h7FFF);     // off gives silence
      send_cmd(CMD_ATTACK, 16'h0000);
      send_cmd(CMD_SAMPLE, 16'h7FFF);
      send_cmd(CMD_SAMPLE, 16'h8000);
      send_cmd(CMD_SAMPLE, 16'h0001);
      send_cmd(CMD_UNUSED, 16'h5A5A);
      send_cmd(CMD_RELEASE, 16'hFFFF);
      send_cmd(CMD_SAMPLE, 16'h7FFF);
      send_cmd(CMD_SAMPLE, 16'hFFFF);
      send_cmd(CMD_RELEASE, 16'h0000);    // release from zero peak
      send_cmd(CMD_SAMPLE, 16'h1234);

      // zero lengths (taken as one), zero target: the step is zero, as the peak already sits at zero
      setup('0, '0, '0, UNITY);
      send_cmd(CMD_ATTACK, 16'h0000);
      send_cmd(CMD_SAMPLE, 16'h8000);
      send_cmd(CMD_SAMPLE, 16'h7FFF);
      send_cmd(CMD_RELEASE, 16'h0000);
      send_cmd(CMD_SAMPLE, 16'h4000);

      // target above unity: attack caps at unity and never holds
      setup('1, LEN_W'(3), LEN_W'(2), '0);
      send_cmd(CMD_ATTACK, 16'h0000);
      repeat (4) send_cmd(CMD_SAMPLE, 16'h7FFF);
      send_cmd(CMD_RELEASE, 16'h0000);
      send_cmd(CMD_SAMPLE, 16'h8000);
      send_cmd(CMD_SAMPLE, 16'h7FFF);

      for (int ph = 0; ph < PHASES; ph++) begin
         calm = (ph == 2 || ph == 5);
         case (ph)
            0:       setup('0, '1, '1, '0);
            PHASES - 1: setup('1, '0, '0, '1);
            default: setup(pick_level(UNITY), pick_len(), pick_len(), pick_level(4096));
         endcase
         run_random(PHASE_ITEMS);
      end
      calm = 1'b0;

      settle();
      $display("Summary: %0d commands sent (%0d samples, %0d triggers, %0d unused codes)",
               n_samples + n_triggers + n_unused, n_samples, n_triggers, n_unused);
      $display("Summary: %0d register settings, %0d results compared", n_settings, checked);
      if (fail_count == 0 && waiting == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: filelist.f
src/arevca_pkg.sv
src/arevca_fifo.sv
src/arevca_front.sv
src/arevca_div.sv
src/arevca_back.sv
src/attack_release_envelope_vca_unit.sv
tb/arevca_checker.sv
tb/tb_attack_release_envelope_vca_unit.sv
